/* rtl/rlcs_pkg.sv */
// ----------------------------------------------------------------------------
// rlcs_pkg
// Shared types, register map and helper functions for the RGB LED chain
// serializer.
// ----------------------------------------------------------------------------
package rlcs_pkg;

    localparam int unsigned COLOR_W   = 24;
    localparam int unsigned TICK_W    = 24;
    localparam int unsigned PULSE_W   = 16;
    localparam int unsigned ADDR_W    = 5;
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned BIT_W     = 5;
    localparam int unsigned LED_COUNT_DEF = 2;

    localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(COLOR_W - 1);

    // Register reset values
    localparam logic [PULSE_W-1:0] ONE_HIGH_RST  = 16'd49;
    localparam logic [PULSE_W-1:0] ONE_LOW_RST   = 16'd27;
    localparam logic [PULSE_W-1:0] ZERO_HIGH_RST = 16'd27;
    localparam logic [PULSE_W-1:0] ZERO_LOW_RST  = 16'd49;
    localparam logic [TICK_W-1:0]  GAP_RST       = 24'd10000;
    localparam logic [COLOR_W-1:0] NO_CHANGE_RST = 24'd1;

    // Register indexes (byte address = 4 * index)
    typedef enum logic [2:0] {
        REG_ONE_HIGH  = 3'd0,
        REG_ONE_LOW   = 3'd1,
        REG_ZERO_HIGH = 3'd2,
        REG_ZERO_LOW  = 3'd3,
        REG_GAP       = 3'd4,
        REG_NO_CHANGE = 3'd5
    } reg_idx_t;

    // Request kinds
    localparam logic KIND_TICK   = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [COLOR_W-1:0] first_color;
        logic [COLOR_W-1:0] second_color;
    } req_item_t;

    typedef struct packed {
        logic pin_level;
        logic busy_res;
        logic rejected;
        logic frame_done;
    } res_item_t;

    typedef struct packed {
        logic [PULSE_W-1:0] one_high_ticks;
        logic [PULSE_W-1:0] one_low_ticks;
        logic [PULSE_W-1:0] zero_high_ticks;
        logic [PULSE_W-1:0] zero_low_ticks;
        logic [TICK_W-1:0]  gap_ticks;
        logic [COLOR_W-1:0] no_change_code;
    } cfg_t;

    // Wire order on the LED chain is green, red, blue
    function automatic logic [COLOR_W-1:0] to_grb(input logic [COLOR_W-1:0] c);
        to_grb = {c[15:8], c[23:16], c[7:0]};
    endfunction

    // A zero count behaves as one tick
    function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
        at_least_one = (v == '0) ? TICK_W'(1) : v;
    endfunction

endpackage

/* rtl/rlcs_regs.sv */
// ----------------------------------------------------------------------------
// rlcs_regs
// APB register bank holding the pulse timing, latch gap and no-change code.
// ----------------------------------------------------------------------------
module rlcs_regs
    import rlcs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.one_high_ticks  <= ONE_HIGH_RST;
            cfg_reg.one_low_ticks   <= ONE_LOW_RST;
            cfg_reg.zero_high_ticks <= ZERO_HIGH_RST;
            cfg_reg.zero_low_ticks  <= ZERO_LOW_RST;
            cfg_reg.gap_ticks       <= GAP_RST;
            cfg_reg.no_change_code  <= NO_CHANGE_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_ONE_HIGH:  cfg_reg.one_high_ticks  <= pwdata[PULSE_W-1:0];
                REG_ONE_LOW:   cfg_reg.one_low_ticks   <= pwdata[PULSE_W-1:0];
                REG_ZERO_HIGH: cfg_reg.zero_high_ticks <= pwdata[PULSE_W-1:0];
                REG_ZERO_LOW:  cfg_reg.zero_low_ticks  <= pwdata[PULSE_W-1:0];
                REG_GAP:       cfg_reg.gap_ticks       <= pwdata[TICK_W-1:0];
                REG_NO_CHANGE: cfg_reg.no_change_code  <= pwdata[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_ONE_HIGH:  prdata = DATA_W'(cfg_reg.one_high_ticks);
            REG_ONE_LOW:   prdata = DATA_W'(cfg_reg.one_low_ticks);
            REG_ZERO_HIGH: prdata = DATA_W'(cfg_reg.zero_high_ticks);
            REG_ZERO_LOW:  prdata = DATA_W'(cfg_reg.zero_low_ticks);
            REG_GAP:       prdata = DATA_W'(cfg_reg.gap_ticks);
            REG_NO_CHANGE: prdata = DATA_W'(cfg_reg.no_change_code);
            default:       prdata = '0;
        endcase
    end

endmodule

/* rtl/rlcs_core.sv */
// ----------------------------------------------------------------------------
// rlcs_core
// Frame sequencer: color store, shift word, bit/slot counters and tick
// timer. Produces one result per accepted request.
// ----------------------------------------------------------------------------
module rlcs_core
    import rlcs_pkg::*;
#(
    parameter int unsigned LED_COUNT = LED_COUNT_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  req_item_t req,
    input  cfg_t      cfg,
    output res_item_t res
);

    localparam int unsigned SLOT_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_HIGH = 4'b0010,
        PH_LOW  = 4'b0100,
        PH_GAP  = 4'b1000
    } phase_t;

    phase_t              phase_reg,  phase_next;
    logic [COLOR_W-1:0]  store_reg  [2];
    logic [COLOR_W-1:0]  store_next [2];
    logic [COLOR_W-1:0]  shift_reg,  shift_next;
    logic [BIT_W-1:0]    bit_reg,    bit_next;
    logic [SLOT_W-1:0]   slot_reg,   slot_next;
    logic [TICK_W-1:0]   tick_reg,   tick_next;

    logic [TICK_W-1:0]   tick_dec;
    logic [SLOT_W-1:0]   slot_inc;
    logic [COLOR_W-1:0]  word_load;
    logic [COLOR_W-1:0]  word_shift;

    always_comb
    begin
        tick_dec   = (tick_reg != '0) ? tick_reg - TICK_W'(1) : '0;
        slot_inc   = slot_reg + SLOT_W'(1);
        // Only slots zero and one are ever written; later slots stay zero
        word_load  = (LED_COUNT > 1 && slot_inc == SLOT_W'(1)) ? to_grb(store_reg[1]) : '0;
        word_shift = {shift_reg[COLOR_W-2:0], 1'b0};

        phase_next    = phase_reg;
        store_next[0] = store_reg[0];
        store_next[1] = store_reg[1];
        shift_next    = shift_reg;
        bit_next      = bit_reg;
        slot_next     = slot_reg;
        tick_next     = tick_reg;
        res           = '0;

        if (accept)
        begin
            if (req.kind == KIND_UPDATE)
            begin
                if (phase_reg != PH_IDLE)
                begin
                    res.rejected  = 1'b1;
                    res.busy_res  = 1'b1;
                    res.pin_level = (phase_reg == PH_HIGH);
                end
                else
                begin
                    if (req.first_color != cfg.no_change_code)
                        store_next[0] = req.first_color;
                    if (LED_COUNT > 1 && req.second_color != cfg.no_change_code)
                        store_next[1] = req.second_color;
                    shift_next   = to_grb(store_next[0]);
                    bit_next     = '0;
                    slot_next    = '0;
                    phase_next   = PH_HIGH;
                    tick_next    = at_least_one(TICK_W'(shift_next[COLOR_W-1] ?
                                   cfg.one_high_ticks : cfg.zero_high_ticks));
                    res.busy_res = 1'b1;
                end
            end
            else if (phase_reg != PH_IDLE)
            begin
                res.busy_res  = 1'b1;
                res.pin_level = (phase_reg == PH_HIGH);
                tick_next     = tick_dec;
                if (tick_dec == '0)
                begin
                    case (phase_reg)
                        PH_HIGH:
                        begin
                            phase_next = PH_LOW;
                            tick_next  = at_least_one(TICK_W'(shift_reg[COLOR_W-1] ?
                                         cfg.one_low_ticks : cfg.zero_low_ticks));
                        end
                        PH_LOW:
                        begin
                            phase_next = PH_HIGH;
                            if (bit_reg == LAST_BIT)
                            begin
                                bit_next = '0;
                                if (slot_reg == SLOT_W'(LED_COUNT - 1))
                                begin
                                    slot_next  = '0;
                                    shift_next = word_shift;
                                    phase_next = PH_GAP;
                                    tick_next  = at_least_one(cfg.gap_ticks);
                                end
                                else
                                begin
                                    slot_next  = slot_inc;
                                    shift_next = word_load;
                                    tick_next  = at_least_one(TICK_W'(word_load[COLOR_W-1] ?
                                                 cfg.one_high_ticks : cfg.zero_high_ticks));
                                end
                            end
                            else
                            begin
                                bit_next   = bit_reg + BIT_W'(1);
                                shift_next = word_shift;
                                tick_next  = at_least_one(TICK_W'(word_shift[COLOR_W-1] ?
                                             cfg.one_high_ticks : cfg.zero_high_ticks));
                            end
                        end
                        PH_GAP:
                        begin
                            phase_next     = PH_IDLE;
                            res.frame_done = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            store_reg[0] <= '0;
            store_reg[1] <= '0;
            shift_reg    <= '0;
            bit_reg      <= '0;
            slot_reg     <= '0;
            tick_reg     <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            store_reg[0] <= store_next[0];
            store_reg[1] <= store_next[1];
            shift_reg    <= shift_next;
            bit_reg      <= bit_next;
            slot_reg     <= slot_next;
            tick_reg     <= tick_next;
        end
    end

endmodule

/* rtl/rlcs_outbuf.sv */
// ----------------------------------------------------------------------------
// rlcs_outbuf
// Result register with one skid entry, so a request can be taken while the
// previous result is still held.
// ----------------------------------------------------------------------------
module rlcs_outbuf
    import rlcs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  res_item_t push_item,
    output logic      full,
    output logic      res_valid,
    input  logic      res_stall,
    output res_item_t res
);

    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    res_item_t out_reg, out_next;
    res_item_t skid_reg, skid_next;
    logic      pop;

    assign pop       = out_valid_reg & ~res_stall;
    assign full      = skid_valid_reg;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (pop || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = push_item;
                out_valid_next = push;
            end
        end
        else if (push)
        begin
            // Hold the waiting result and park the new one
            skid_next       = push_item;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule

/* rtl/rgb_led_chain_serializer.sv */
// ----------------------------------------------------------------------------
// rgb_led_chain_serializer
// Single-wire smart RGB LED chain driver: color updates, GRB pulse-width
// bit timing and latch gap, one result per request.
// ----------------------------------------------------------------------------
//
//   Channel  Signals                        Direction  Payload
//   req      req_valid, req_stall, req      into block req_item_t (kind, colors)
//   res      res_valid, res_stall, res      out of     res_item_t (pin, flags)
//   cfg      psel/penable/pwrite/paddr/...  APB slave  32-bit registers
//
// Each request is handled combinationally: the sequencer state registers feed
// short next-state logic, and the result is registered in the result register
// or the skid entry, so one request per clock is sustained while req_stall is low.
// Reset clears the color store, counters and configuration to their defaults.
// A stalled result is held; one more request is parked in a skid entry, and
// req_stall rises only while that entry is occupied.
// ----------------------------------------------------------------------------
module rgb_led_chain_serializer
    import rlcs_pkg::*;
#(
    parameter int unsigned LED_COUNT = LED_COUNT_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  req_item_t         req,
    output logic              res_valid,
    input  logic              res_stall,
    output res_item_t         res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t      cfg;
    res_item_t core_res;
    logic      buf_full;
    logic      accept;

    // Take a request whenever the skid entry is free
    assign req_stall = buf_full;
    assign accept    = req_valid & ~buf_full;

    rlcs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rlcs_core #(
        .LED_COUNT (LED_COUNT)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .req    (req),
        .cfg    (cfg),
        .res    (core_res)
    );

    rlcs_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_item (core_res),
        .full      (buf_full),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule

/* rtl/rlcs_checker.sv */
// ----------------------------------------------------------------------------
// rlcs_checker
// Port-level checks for the RGB LED chain serializer, bound to the top level.
// ----------------------------------------------------------------------------
module rlcs_checker
    import rlcs_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_stall,
    input logic      res_valid,
    input logic      res_stall,
    input res_item_t res
);

    // A rejection only happens during a frame
    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.rejected |-> res.busy_res)
        else $error("rejected result without busy");

    // The gap end drives the pin low and still reports busy
    a_done_low: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.frame_done |-> res.busy_res && !res.pin_level && !res.rejected)
        else $error("frame_done with pin high or not busy");

    // Request stall only follows a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(req_stall) |-> $past(res_valid && res_stall))
        else $error("request stalled without result back-pressure");

    // Held result stays put
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("stalled result changed");

endmodule

bind rgb_led_chain_serializer rlcs_checker u_rlcs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_stall (req_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);
